/* sv/stma_pkg.sv */
package stma_pkg;

    localparam int MAX_ENTRIES   = 32;
    localparam int INDEX_WIDTH   = 12;
    localparam int VALUE_WIDTH   = 32;
    localparam int DIM_WIDTH     = 13;
    localparam int KIND_WIDTH    = 2;
    localparam int STATUS_WIDTH  = 2;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int ADDR_WIDTH    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_WIDTH     = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_WIDTH   = 2 * INDEX_WIDTH + VALUE_WIDTH;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_FIRST  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_ENTRY    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ROWS_FIRST  = 2'd0,
        CFG_COLS_FIRST  = 2'd1,
        CFG_ROWS_SECOND = 2'd2,
        CFG_COLS_SECOND = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] row;
        logic [INDEX_WIDTH-1:0] col;
        logic [VALUE_WIDTH-1:0] value;
    } t_entry;

    typedef struct packed {
        logic    start;
        logic    fault;
        t_status code;
    } t_run_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_run_rsp;

endpackage

/* sv/stma_if.sv */
interface stma_in_if;
    import stma_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         kind;
    logic [INDEX_WIDTH-1:0]        row;
    logic [INDEX_WIDTH-1:0]        col;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface stma_out_if;
    import stma_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [STATUS_WIDTH-1:0]       status;
    logic [INDEX_WIDTH-1:0]        out_row;
    logic [INDEX_WIDTH-1:0]        out_col;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic                          last;

    modport source (output valid, status, out_row, out_col, out_value, last, input ready);
    modport sink   (input valid, status, out_row, out_col, out_value, last, output ready);
endinterface

interface stma_cfg_if;
    import stma_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [DIM_WIDTH-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/stma_ram.sv */
module stma_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 56,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/stma_merge.sv */
module stma_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stma_pkg::t_run_req           i_req,
    output stma_pkg::t_run_rsp           o_rsp,
    input  logic [stma_pkg::CNT_WIDTH-1:0]  i_cnt_first,
    input  logic [stma_pkg::CNT_WIDTH-1:0]  i_cnt_second,
    input  stma_pkg::t_entry             i_first_rd,
    input  stma_pkg::t_entry             i_second_rd,
    output logic [stma_pkg::ADDR_WIDTH-1:0] o_first_raddr,
    output logic [stma_pkg::ADDR_WIDTH-1:0] o_second_raddr,
    stma_out_if.source                   o_out
);
    import stma_pkg::*;

    t_state                 r_state, n_state;
    logic [CNT_WIDTH-1:0]   r_a, n_a;
    logic [CNT_WIDTH-1:0]   r_b, n_b;
    logic                   r_pend_valid, n_pend_valid;
    t_entry                 r_pend, n_pend;
    t_status                r_code;
    logic                   r_out_valid;
    t_status                r_out_status, n_out_status;
    t_entry                 r_out_entry, n_out_entry;
    logic                   r_out_last, n_out_last;
    logic                   load_out;

    logic                       a_ok, b_ok, a_lt, a_gt;
    logic                       take_a, take_b, take_both;
    logic                       walk_done, emit, out_free;
    logic                       step, finish_merge, finish_status;
    logic [VALUE_WIDTH-1:0]     sum;
    logic [2*INDEX_WIDTH-1:0]   key_a, key_b;
    t_entry                     new_entry;

    assign a_ok      = r_a < i_cnt_first;
    assign b_ok      = r_b < i_cnt_second;
    assign key_a     = {i_first_rd.row, i_first_rd.col};
    assign key_b     = {i_second_rd.row, i_second_rd.col};
    assign a_lt      = key_a < key_b;
    assign a_gt      = key_a > key_b;
    assign take_a    = a_ok && (!b_ok || a_lt);
    assign take_b    = b_ok && (!a_ok || a_gt);
    assign take_both = a_ok && b_ok && !a_lt && !a_gt;
    assign sum       = i_first_rd.value + i_second_rd.value;
    assign walk_done = !a_ok && !b_ok;
    assign emit      = take_a || take_b || (take_both && (sum != '0));
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        if (take_both) begin
            new_entry = '{row: i_first_rd.row, col: i_first_rd.col, value: sum};
        end else if (take_a) begin
            new_entry = i_first_rd;
        end else begin
            new_entry = i_second_rd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state = i_req.fault ? S_STATUS : S_MERGE;
                end
            end
            S_MERGE: begin
                if (out_free && walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        step          = (r_state == S_MERGE) && out_free && !walk_done;
        finish_merge  = (r_state == S_MERGE) && out_free && walk_done;
        finish_status = (r_state == S_STATUS) && out_free;

        n_a          = r_a;
        n_b          = r_b;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        load_out     = 1'b0;
        n_out_status = ST_ENTRY;
        n_out_entry  = r_pend;
        n_out_last   = 1'b0;

        if (r_state == S_IDLE) begin
            n_a          = '0;
            n_b          = '0;
            n_pend_valid = 1'b0;
        end

        if (step) begin
            n_a = r_a + CNT_WIDTH'(take_a || take_both);
            n_b = r_b + CNT_WIDTH'(take_b || take_both);
            if (emit) begin
                n_pend       = new_entry;
                n_pend_valid = 1'b1;
                load_out     = r_pend_valid;
            end
        end

        if (finish_merge) begin
            load_out     = 1'b1;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
            if (!r_pend_valid) begin
                n_out_status = ST_EMPTY;
                n_out_entry  = '0;
            end
        end

        if (finish_status) begin
            load_out     = 1'b1;
            n_out_last   = 1'b1;
            n_out_status = r_code;
            n_out_entry  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_a          <= '0;
            r_b          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_a          <= n_a;
            r_b          <= n_b;
            r_pend_valid <= n_pend_valid;
            if (out_free) begin
                r_out_valid <= load_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (i_req.start) begin
            r_code <= i_req.code;
        end
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_entry  <= n_out_entry;
            r_out_last   <= n_out_last;
        end
    end

    assign o_first_raddr  = n_a[ADDR_WIDTH-1:0];
    assign o_second_raddr = n_b[ADDR_WIDTH-1:0];

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.done = finish_merge || finish_status;

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.out_row   = r_out_entry.row;
    assign o_out.out_col   = r_out_entry.col;
    assign o_out.out_value = r_out_entry.value;
    assign o_out.last      = r_out_last;
endmodule

/* sv/sparse_triplet_matrix_add.sv */
// Channel   Direction  Payload                                   Transaction
// i_in      sink       kind, row, col, value                     valid & ready
// o_out     source     status, out_row, out_col, out_value, last valid & ready
// i_cfg     sink       index, data                               valid & ready
//
// A load does not make the block busy; the input stays ready after it.
// A finish with no mismatch or overflow walks both entry memories through one read port
// each and emits at most one merged entry per cycle while the output is not stalled.
// Reset is synchronous and clears counts, flags and control; memories keep no reset.
// A stalled output holds the walk; no input is taken until the final result is registered.
module sparse_triplet_matrix_add (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stma_in_if.sink     i_in,
    stma_out_if.source  o_out,
    stma_cfg_if.sink    i_cfg
);
    import stma_pkg::*;

    logic [DIM_WIDTH-1:0]   r_rows_first, r_cols_first, r_rows_second, r_cols_second;
    logic [CNT_WIDTH-1:0]   r_cnt_first, r_cnt_second;
    logic                   r_overflow;

    t_run_req               req;
    t_run_rsp               rsp;
    logic                   in_take;
    logic                   load_first, load_second, finish;
    logic                   full_first, full_second;
    logic                   mismatch;
    t_entry                 wr_entry;
    t_entry                 first_rd, second_rd;
    logic [ADDR_WIDTH-1:0]  first_raddr, second_raddr;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !rsp.busy;
    assign in_take     = i_in.valid && i_in.ready;

    always_comb begin
        load_first  = 1'b0;
        load_second = 1'b0;
        finish      = 1'b0;
        unique case (t_kind'(i_in.kind))
            KIND_FIRST:  load_first  = in_take;
            KIND_SECOND: load_second = in_take;
            KIND_FINISH: finish      = in_take;
            default: ;
        endcase
    end

    assign full_first  = (r_cnt_first == CNT_WIDTH'(MAX_ENTRIES));
    assign full_second = (r_cnt_second == CNT_WIDTH'(MAX_ENTRIES));
    assign mismatch    = (r_rows_first != r_rows_second) || (r_cols_first != r_cols_second);
    assign wr_entry    = '{row: i_in.row, col: i_in.col, value: i_in.value};

    assign req.start = finish;
    assign req.fault = mismatch || r_overflow;
    assign req.code  = mismatch ? ST_MISMATCH : ST_OVERFLOW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_first  <= DIM_WIDTH'(1);
            r_cols_first  <= DIM_WIDTH'(1);
            r_rows_second <= DIM_WIDTH'(1);
            r_cols_second <= DIM_WIDTH'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_ROWS_FIRST:  r_rows_first  <= i_cfg.data;
                CFG_COLS_FIRST:  r_cols_first  <= i_cfg.data;
                CFG_ROWS_SECOND: r_rows_second <= i_cfg.data;
                CFG_COLS_SECOND: r_cols_second <= i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_overflow   <= 1'b0;
        end else if (rsp.done) begin
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_overflow   <= 1'b0;
        end else begin
            if (load_first) begin
                if (full_first) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_cnt_first <= r_cnt_first + CNT_WIDTH'(1);
                end
            end
            if (load_second) begin
                if (full_second) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_cnt_second <= r_cnt_second + CNT_WIDTH'(1);
                end
            end
        end
    end

    stma_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENTRY_WIDTH),
        .ADDR_W(ADDR_WIDTH)
    ) u_first_ram (
        .i_clk  (i_clk),
        .i_we   (load_first && !full_first),
        .i_waddr(r_cnt_first[ADDR_WIDTH-1:0]),
        .i_wdata(wr_entry),
        .i_raddr(first_raddr),
        .o_rdata(first_rd)
    );

    stma_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENTRY_WIDTH),
        .ADDR_W(ADDR_WIDTH)
    ) u_second_ram (
        .i_clk  (i_clk),
        .i_we   (load_second && !full_second),
        .i_waddr(r_cnt_second[ADDR_WIDTH-1:0]),
        .i_wdata(wr_entry),
        .i_raddr(second_raddr),
        .o_rdata(second_rd)
    );

    stma_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_rsp         (rsp),
        .i_cnt_first   (r_cnt_first),
        .i_cnt_second  (r_cnt_second),
        .i_first_rd    (first_rd),
        .i_second_rd   (second_rd),
        .o_first_raddr (first_raddr),
        .o_second_raddr(second_raddr),
        .o_out         (o_out)
    );
endmodule

/* sv/stma_checker.sv */
module stma_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic [stma_pkg::KIND_WIDTH-1:0]   i_in_kind,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [stma_pkg::STATUS_WIDTH-1:0] i_out_status,
    input logic [stma_pkg::INDEX_WIDTH-1:0]  i_out_row,
    input logic [stma_pkg::INDEX_WIDTH-1:0]  i_out_col,
    input logic [stma_pkg::VALUE_WIDTH-1:0]  i_out_value,
    input logic                              i_out_last
);
    import stma_pkg::*;

    a_finish_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_kind == KIND_FINISH)) |=> !i_in_ready)
        else $error("input still ready after a finish transaction");

    a_status_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status != ST_ENTRY)) |->
        (i_out_last && (i_out_row == '0) && (i_out_col == '0) && (i_out_value == '0)))
        else $error("status result is not a final zero item");

    a_no_open_run_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready while a run still has results to deliver");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_status) && $stable(i_out_value) && $stable(i_out_last)))
        else $error("stalled result changed");
endmodule

bind sparse_triplet_matrix_add stma_checker u_stma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_status(o_out.status),
    .i_out_row   (o_out.out_row),
    .i_out_col   (o_out.out_col),
    .i_out_value (o_out.out_value),
    .i_out_last  (o_out.last)
);
